### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante (clock aclk, reset aresetn).
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/spl_pkg.sv
`default_nettype none

package spl_pkg;

    // Register field widths
    localparam int GAIN_W     = 17;
    localparam int HOLD_W     = 16;
    localparam int REL_W      = 16;
    localparam int THR_W      = 23;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = THR_W;

    // Divider: quotient bits, one per step
    localparam int QUO_W     = 16;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = 4;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OUTPUT_GAIN    = 3'd0,
        REG_LIMITER_ENABLE = 3'd1,
        REG_MUTE           = 3'd2,
        REG_HOLD_SAMPLES   = 3'd3,
        REG_RELEASE_FACTOR = 3'd4,
        REG_THRESHOLD      = 3'd5,
        REG_CEILING_GAIN   = 3'd6
    } cfg_reg_t;

    // Reset values
    localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST    = 17'd65536;
    localparam logic              LIMITER_ENABLE_RST = 1'b1;
    localparam logic              MUTE_RST           = 1'b0;
    localparam logic [HOLD_W-1:0] HOLD_RST           = 16'd375;
    localparam logic [REL_W-1:0]  RELEASE_RST        = 16'd65454;
    localparam logic [THR_W-1:0]  THRESHOLD_RST      = 23'd8304721;
    localparam logic [GAIN_W-1:0] CEILING_RST        = 17'd65536;
    localparam logic [HOLD_W-1:0] TIMER_B_RST        = HOLD_RST / 16'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] output_gain;
        logic              limiter_enable;
        logic              mute;
        logic [HOLD_W-1:0] hold_samples;
        logic [REL_W-1:0]  release_factor;
        logic [THR_W-1:0]  threshold;
        logic [GAIN_W-1:0] ceiling_gain;
    } cfg_t;

    // Microcode fields
    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {A_LEFT, A_RIGHT, A_DLO, A_DHI, A_QUO} a_sel_t;
    typedef enum logic [1:0] {B_OGAIN, B_RELEASE, B_CGAIN, B_LGAIN} b_sel_t;
    typedef enum logic [2:0] {
        WB_NONE, WB_LEFT, WB_RIGHT, WB_REL_LO, WB_REL_HI, WB_GAIN
    } wb_t;
    typedef enum logic [3:0] {
        EX_NONE, EX_LOAD, EX_TRACK, EX_DIFF, EX_DIV_INIT, EX_DIV_STEP,
        EX_GAIN_CEIL, EX_CLEAR, EX_EMIT
    } ex_t;
    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_MUTE, C_BYPASS, C_NO_LIMIT, C_DIV_MORE
    } cond_t;

    typedef struct packed {
        a_sel_t a_sel;
        b_sel_t b_sel;
        wb_t    wb;
        ex_t    ex;
        cond_t  cond;
        pc_t    target;
    } ucode_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic stall;
        logic mute;
        logic bypass;
        logic no_limit;
        logic div_more;
    } dp_status_t;

    // Program steps
    localparam pc_t ST_LOAD      = 5'd0;
    localparam pc_t ST_MUL_L1    = 5'd1;
    localparam pc_t ST_MUL_R1    = 5'd2;
    localparam pc_t ST_WB_R1     = 5'd3;
    localparam pc_t ST_TRACK     = 5'd4;
    localparam pc_t ST_DIFF      = 5'd5;
    localparam pc_t ST_REL_LO    = 5'd6;
    localparam pc_t ST_REL_HI    = 5'd7;
    localparam pc_t ST_REL_WB    = 5'd8;
    localparam pc_t ST_DIV_INIT  = 5'd9;
    localparam pc_t ST_DIV_STEP  = 5'd10;
    localparam pc_t ST_MUL_Q     = 5'd11;
    localparam pc_t ST_WB_GAIN   = 5'd12;
    localparam pc_t ST_GAIN_CEIL = 5'd13;
    localparam pc_t ST_MUL_L2    = 5'd14;
    localparam pc_t ST_MUL_R2    = 5'd15;
    localparam pc_t ST_WB_R2     = 5'd16;
    localparam pc_t ST_CLEAR     = 5'd17;
    localparam pc_t ST_EMIT      = 5'd18;

    function automatic ucode_t uc(a_sel_t a, b_sel_t b, wb_t w, ex_t e, cond_t c, pc_t t);
        ucode_t u;
        u = '{a_sel: a, b_sel: b, wb: w, ex: e, cond: c, target: t};
        return u;
    endfunction

    // Control store: one word per step
    function automatic ucode_t ucode_fetch(pc_t pc);
        ucode_t u;
        case (pc)
            ST_LOAD:      u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_LOAD,      C_MUTE,     ST_CLEAR);
            ST_MUL_L1:    u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_NONE,      C_NEXT,     ST_LOAD);
            ST_MUL_R1:    u = uc(A_RIGHT, B_OGAIN,   WB_LEFT,   EX_NONE,      C_NEXT,     ST_LOAD);
            ST_WB_R1:     u = uc(A_LEFT,  B_OGAIN,   WB_RIGHT,  EX_NONE,      C_BYPASS,   ST_EMIT);
            ST_TRACK:     u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_TRACK,     C_NEXT,     ST_LOAD);
            ST_DIFF:      u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_DIFF,      C_NEXT,     ST_LOAD);
            ST_REL_LO:    u = uc(A_DLO,   B_RELEASE, WB_NONE,   EX_NONE,      C_NEXT,     ST_LOAD);
            ST_REL_HI:    u = uc(A_DHI,   B_RELEASE, WB_REL_LO, EX_NONE,      C_NEXT,     ST_LOAD);
            ST_REL_WB:    u = uc(A_LEFT,  B_OGAIN,   WB_REL_HI, EX_NONE,      C_NEXT,     ST_LOAD);
            ST_DIV_INIT:  u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_DIV_INIT,  C_NO_LIMIT, ST_GAIN_CEIL);
            ST_DIV_STEP:  u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_DIV_STEP,  C_DIV_MORE, ST_DIV_STEP);
            ST_MUL_Q:     u = uc(A_QUO,   B_CGAIN,   WB_NONE,   EX_NONE,      C_NEXT,     ST_LOAD);
            ST_WB_GAIN:   u = uc(A_LEFT,  B_OGAIN,   WB_GAIN,   EX_NONE,      C_ALWAYS,   ST_MUL_L2);
            ST_GAIN_CEIL: u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_GAIN_CEIL, C_NEXT,     ST_LOAD);
            ST_MUL_L2:    u = uc(A_LEFT,  B_LGAIN,   WB_NONE,   EX_NONE,      C_NEXT,     ST_LOAD);
            ST_MUL_R2:    u = uc(A_RIGHT, B_LGAIN,   WB_LEFT,   EX_NONE,      C_NEXT,     ST_LOAD);
            ST_WB_R2:     u = uc(A_LEFT,  B_OGAIN,   WB_RIGHT,  EX_NONE,      C_ALWAYS,   ST_EMIT);
            ST_CLEAR:     u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_CLEAR,     C_NEXT,     ST_LOAD);
            ST_EMIT:      u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_EMIT,      C_ALWAYS,   ST_LOAD);
            default:      u = uc(A_LEFT,  B_OGAIN,   WB_NONE,   EX_NONE,      C_ALWAYS,   ST_LOAD);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

### src/spl_cfg_regs.sv
`default_nettype none

module spl_cfg_regs
    import spl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write; unknown indexes leave everything alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_OUTPUT_GAIN:    cfg_next.output_gain    = cfg_data[GAIN_W-1:0];
                REG_LIMITER_ENABLE: cfg_next.limiter_enable = cfg_data[0];
                REG_MUTE:           cfg_next.mute           = cfg_data[0];
                REG_HOLD_SAMPLES:   cfg_next.hold_samples   = cfg_data[HOLD_W-1:0];
                REG_RELEASE_FACTOR: cfg_next.release_factor = cfg_data[REL_W-1:0];
                REG_THRESHOLD:      cfg_next.threshold      = cfg_data[THR_W-1:0];
                REG_CEILING_GAIN:   cfg_next.ceiling_gain   = cfg_data[GAIN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.output_gain    <= OUTPUT_GAIN_RST;
            cfg_reg.limiter_enable <= LIMITER_ENABLE_RST;
            cfg_reg.mute           <= MUTE_RST;
            cfg_reg.hold_samples   <= HOLD_RST;
            cfg_reg.release_factor <= RELEASE_RST;
            cfg_reg.threshold      <= THRESHOLD_RST;
            cfg_reg.ceiling_gain   <= CEILING_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### src/spl_sequencer.sv
`default_nettype none

module spl_sequencer
    import spl_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_status_t stat,
    output ucode_t          ctrl
);

    `include "assert_macros.svh"

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take_jump;

    assign ctrl = ucode_fetch(pc_reg);

    // Evaluate the jump condition of the current word
    always_comb begin
        case (ctrl.cond)
            C_NEXT:     take_jump = 1'b0;
            C_ALWAYS:   take_jump = 1'b1;
            C_MUTE:     take_jump = stat.mute;
            C_BYPASS:   take_jump = stat.bypass;
            C_NO_LIMIT: take_jump = stat.no_limit;
            C_DIV_MORE: take_jump = stat.div_more;
            default:    take_jump = 1'b0;
        endcase
    end

    // Hold on stall, otherwise jump or advance
    always_comb begin
        if (stat.stall) begin
            pc_next = pc_reg;
        end else if (take_jump) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_LOAD;
        end else begin
            pc_reg <= pc_next;
        end
    end

    `ASSERT_NEXT(a_load_next, (ctrl.ex == EX_LOAD) && !stat.stall,
        (pc_reg == ST_MUL_L1) || (pc_reg == ST_CLEAR), "accepted word did not start a pass")

endmodule

`default_nettype wire

### src/spl_datapath.sv
`default_nettype none

module spl_datapath
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire ucode_t             ctrl,
    output dp_status_t              stat,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata
);

    `include "assert_macros.svh"

    localparam int SB   = SAMPLE_BITS;
    localparam int PK_W = SB - 1;              // peak magnitude
    localparam int EW   = PK_W + FRAC_W;       // envelope, Q(SB-1).16
    localparam int H    = (EW + 1) / 2;        // low half of release difference
    localparam int HI_W = EW - H;
    localparam int AW0  = (SB > H + 1) ? SB : H + 1;
    localparam int AW   = (AW0 > GAIN_W) ? AW0 : GAIN_W;
    localparam int BW   = GAIN_W + 1;
    localparam int PW   = AW + BW;
    localparam int SW   = PW + H + 1;
    localparam int CW   = (EW > THR_W + FRAC_W) ? EW : THR_W + FRAC_W;
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

    // Working samples and multiplier
    logic signed [SB-1:0]     left_reg, right_reg;
    logic signed [PW-1:0]     prod_reg;
    logic [PW-1:0]            acc_reg;
    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;

    // Limiter state
    logic [HOLD_W-1:0]        timer_a_reg, timer_b_reg;
    logic [HOLD_W-1:0]        timer_a_next, timer_b_next;
    logic [PK_W-1:0]          peak_a_reg, peak_b_reg;
    logic [PK_W-1:0]          peak_a_next, peak_b_next;
    logic [EW-1:0]            env_reg, m_reg, d_reg;
    logic [EW-1:0]            rem_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [GAIN_W-1:0]        gain_reg;

    // Output slot
    logic                     m_tvalid_reg;
    logic [SB-1:0]            out_l_reg, out_r_reg;
    logic                     out_free;

    // Combinational helpers
    logic [SB-1:0]            abs_l, abs_r, abs_max;
    logic [PK_W-1:0]          frame_peak, peak_max;
    logic [HOLD_W:0]          inc_a, inc_b;
    logic                     clr_a, clr_b;
    logic [PK_W-1:0]          base_a, base_b;
    logic [EW-1:0]            m_now;
    logic [SW-1:0]            rel_sum;
    logic [EW:0]              rem_dbl;
    logic                     rem_ge;

    function automatic logic signed [SB-1:0] round_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + PW'(32768)) >>> FRAC_W;
        if (t > SAT_HI) begin
            t = SAT_HI;
        end else if (t < SAT_LO) begin
            t = SAT_LO;
        end
        return SB'(t);
    endfunction

    // Operand select
    always_comb begin
        case (ctrl.a_sel)
            A_LEFT:  mul_a = AW'(left_reg);
            A_RIGHT: mul_a = AW'(right_reg);
            A_DLO:   mul_a = AW'({1'b0, d_reg[H-1:0]});
            A_DHI:   mul_a = AW'({1'b0, d_reg[EW-1:H]});
            A_QUO:   mul_a = AW'({1'b0, quo_reg});
            default: mul_a = AW'(left_reg);
        endcase
        case (ctrl.b_sel)
            B_OGAIN:   mul_b = {1'b0, cfg.output_gain};
            B_RELEASE: mul_b = {2'b00, cfg.release_factor};
            B_CGAIN:   mul_b = {1'b0, cfg.ceiling_gain};
            B_LGAIN:   mul_b = {1'b0, gain_reg};
            default:   mul_b = {1'b0, cfg.output_gain};
        endcase
    end

    // Frame peak: larger magnitude, saturated to the peak range
    always_comb begin
        abs_l      = left_reg[SB-1] ? SB'(-left_reg) : SB'(left_reg);
        abs_r      = right_reg[SB-1] ? SB'(-right_reg) : SB'(right_reg);
        abs_max    = (abs_r > abs_l) ? abs_r : abs_l;
        frame_peak = abs_max[SB-1] ? {PK_W{1'b1}} : abs_max[PK_W-1:0];
    end

    // Hold trackers: clear past the hold length, then take the new maximum
    always_comb begin
        inc_a        = {1'b0, timer_a_reg} + 17'd1;
        inc_b        = {1'b0, timer_b_reg} + 17'd1;
        clr_a        = inc_a > {1'b0, cfg.hold_samples};
        clr_b        = inc_b > {1'b0, cfg.hold_samples};
        timer_a_next = clr_a ? '0 : inc_a[HOLD_W-1:0];
        timer_b_next = clr_b ? '0 : inc_b[HOLD_W-1:0];
        base_a       = clr_a ? '0 : peak_a_reg;
        base_b       = clr_b ? '0 : peak_b_reg;
        peak_a_next  = (frame_peak > base_a) ? frame_peak : base_a;
        peak_b_next  = (frame_peak > base_b) ? frame_peak : base_b;
    end

    // Envelope target, release sum and divider step
    always_comb begin
        peak_max = (peak_a_reg > peak_b_reg) ? peak_a_reg : peak_b_reg;
        m_now    = {peak_max, {FRAC_W{1'b0}}};
        rel_sum  = (SW'(prod_reg) << H) + SW'(acc_reg);
        rem_dbl  = {rem_reg, 1'b0};
        rem_ge   = rem_dbl >= {1'b0, env_reg};
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (ctrl.ex == EX_LOAD);

    always_comb begin
        stat.stall    = ((ctrl.ex == EX_LOAD) && !s_tvalid) ||
                        ((ctrl.ex == EX_EMIT) && !out_free);
        stat.mute     = cfg.mute;
        stat.bypass   = !cfg.limiter_enable;
        stat.no_limit = !(CW'(env_reg) > CW'({cfg.threshold, {FRAC_W{1'b0}}}));
        stat.div_more = cnt_reg != CNT_W'(DIV_STEPS - 1);
    end

    // Multiplier register, product writeback and execute ops
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);

        case (ctrl.wb)
            WB_LEFT:   left_reg  <= round_sat(prod_reg);
            WB_RIGHT:  right_reg <= round_sat(prod_reg);
            WB_REL_LO: acc_reg   <= prod_reg;
            WB_GAIN:   gain_reg  <= prod_reg[GAIN_W+FRAC_W-1:FRAC_W];
            default: begin
            end
        endcase

        case (ctrl.ex)
            EX_LOAD: begin
                left_reg  <= s_tdata[SB-1:0];
                right_reg <= s_tdata[2*SB-1:SB];
            end
            EX_DIFF: begin
                m_reg <= m_now;
                d_reg <= (env_reg >= m_now) ? env_reg - m_now : '0;
            end
            EX_DIV_INIT: begin
                rem_reg <= EW'({cfg.threshold, {FRAC_W{1'b0}}});
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            EX_DIV_STEP: begin
                rem_reg <= rem_ge ? EW'(rem_dbl - {1'b0, env_reg}) : EW'(rem_dbl);
                quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            EX_GAIN_CEIL: gain_reg <= cfg.ceiling_gain;
            EX_CLEAR: begin
                left_reg  <= '0;
                right_reg <= '0;
            end
            EX_EMIT: begin
                if (out_free) begin
                    out_l_reg <= left_reg;
                    out_r_reg <= right_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Limiter state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_a_reg  <= '0;
            timer_b_reg  <= TIMER_B_RST;
            peak_a_reg   <= '0;
            peak_b_reg   <= '0;
            env_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ctrl.ex == EX_TRACK) begin
                timer_a_reg <= timer_a_next;
                timer_b_reg <= timer_b_next;
                peak_a_reg  <= peak_a_next;
                peak_b_reg  <= peak_b_next;
            end
            if (ctrl.wb == WB_REL_HI) begin
                env_reg <= m_reg + EW'(rel_sum >> FRAC_W);
            end
            if ((ctrl.ex == EX_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'({out_r_reg, out_l_reg});

    `ASSERT_SAME(a_div_rem, ctrl.ex == EX_DIV_STEP, rem_reg < env_reg,
        "divider remainder not below envelope")
    `ASSERT_NEXT(a_emit_valid, (ctrl.ex == EX_EMIT) && !stat.stall, m_tvalid,
        "emitted word not presented")

endmodule

`default_nettype wire

### src/stereo_peak_hold_limiter.sv
`default_nettype none

// Stereo output stage with peak-hold brickwall limiter. One word on s_ is one
// stereo frame; one word on m_ is the matching processed frame, in order. A
// microcoded sequencer steps a single multiplier and a restoring divider per
// frame. A frame that goes through the limiter and ends above threshold runs
// the 16 iterations of the one-bit-per-cycle divider plus the multiplier passes
// around it; below threshold the divider is skipped, and a bypassed or muted
// frame skips the limiter. The finished frame sits in an output register, so
// the next frame is accepted while it waits; on the output side the sequencer
// stalls only when a second frame finishes before the first is taken. The user
// must write registers over cfg_* only while idle; the block does not enforce it.
module stereo_peak_hold_limiter
    import spl_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_W-1:0]    s_tdata,   // sample_left, sample_right
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata,   // out_left, out_right
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t       cfg;
    ucode_t     ctrl;
    dp_status_t stat;

    spl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spl_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    spl_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top
    import spl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] S_MAX = 24'h7FFFFF;
    localparam logic [23:0] S_MIN = 24'h800000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_OFF = 300;
    localparam int PHASES = 12;
    localparam int FRAMES_PER_PHASE = 70;

    typedef struct packed {
        logic [23:0] right;
        logic [23:0] left;
    } stereo_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;    // sample_left, sample_right
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;         // out_left, out_right
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;
    int quiet_cycles = 0;

    // Shadow of the limiter: registers, hold trackers, envelope, pending frames
    class limiter_shadow;
        longint unsigned out_gain, lim_on, muted, hold_len, release_k, thresh, ceil_gain;
        longint unsigned hold_timer[2];
        longint unsigned held_peak[2];
        longint unsigned env;
        stereo_t expected_frames[$];
        int mismatch_count;

        function new();
            out_gain = 65536;
            lim_on = 1;
            muted = 0;
            hold_len = 375;
            release_k = 65454;
            thresh = 8304721;
            ceil_gain = 65536;
            hold_timer[0] = 0;
            hold_timer[1] = 375 / 2;
            held_peak[0] = 0;
            held_peak[1] = 0;
            env = 0;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_OUTPUT_GAIN:    out_gain = val[16:0];
                REG_LIMITER_ENABLE: lim_on = val[0];
                REG_MUTE:           muted = val[0];
                REG_HOLD_SAMPLES:   hold_len = val[15:0];
                REG_RELEASE_FACTOR: release_k = val[15:0];
                REG_THRESHOLD:      thresh = val[22:0];
                REG_CEILING_GAIN:   ceil_gain = val[16:0];
                default: ;
            endcase
        endfunction

        // Q16 gain, halves rounded up, saturated to 24 bits
        function longint apply_q16(longint x, longint unsigned g);
            longint p;
            longint r;
            p = x * longint'(g) + 32768;
            r = p >>> 16;
            if (r > 8388607) r = 8388607;
            if (r < -8388608) r = -8388608;
            return r;
        endfunction

        function void take_frame(logic [47:0] word);
            stereo_t in_f;
            stereo_t out_f;
            longint l, r;
            longint unsigned fp, mag_r, m, gain, q;
            in_f = word;
            if (muted != 0) begin
                expected_frames.push_back('0);
                return;
            end
            l = apply_q16(longint'($signed(in_f.left)), out_gain);
            r = apply_q16(longint'($signed(in_f.right)), out_gain);
            if (lim_on != 0) begin
                fp = (l < 0) ? -l : l;
                mag_r = (r < 0) ? -r : r;
                if (mag_r > fp) fp = mag_r;
                if (fp > 8388607) fp = 8388607;
                // advance both staggered trackers
                for (int k = 0; k < 2; k++) begin
                    if (hold_timer[k] + 1 > hold_len) begin
                        hold_timer[k] = 0;
                        held_peak[k] = 0;
                    end else begin
                        hold_timer[k] = hold_timer[k] + 1;
                    end
                    if (fp > held_peak[k]) held_peak[k] = fp;
                end
                // jump up to the held peak or decay toward it
                m = ((held_peak[0] > held_peak[1]) ? held_peak[0] : held_peak[1]) << 16;
                if (env < m) env = m;
                else env = m + ((release_k * (env - m)) >> 16);
                if (env > (thresh << 16)) begin
                    q = (thresh << 32) / env;
                    gain = (q * ceil_gain) >> 16;
                end else begin
                    gain = ceil_gain;
                end
                l = apply_q16(l, gain);
                r = apply_q16(r, gain);
            end
            out_f.left = 24'(l);
            out_f.right = 24'(r);
            expected_frames.push_back(out_f);
        endfunction

        function void match_result(logic [47:0] word);
            stereo_t got;
            stereo_t want;
            got = word;
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected output word, expected none, actual %h", $time, word);
                mismatch_count++;
                return;
            end
            want = expected_frames.pop_front();
            if (got.left !== want.left) begin
                $display("%0t: out_left expected %0d, actual %0d",
                         $time, $signed(want.left), $signed(got.left));
                mismatch_count++;
            end
            if (got.right !== want.right) begin
                $display("%0t: out_right expected %0d, actual %0d",
                         $time, $signed(want.right), $signed(got.right));
                mismatch_count++;
            end
        endfunction
    endclass

    limiter_shadow shadow = new();

    stereo_peak_hold_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watch every handshake: feed the shadow, check results, count quiet cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) shadow.set_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) shadow.take_frame(s_tdata);
            if (m_tvalid && m_tready) shadow.match_result(m_tdata);
        end
        if (!aresetn || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
                || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (stall_cycles) @(posedge aclk);
                stall_cycles = 0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic apply_settings(input int unsigned gain, en, mu, hold, rel, thr, ceil);
        write_reg(REG_OUTPUT_GAIN, gain);
        write_reg(REG_LIMITER_ENABLE, en);
        write_reg(REG_MUTE, mu);
        write_reg(REG_HOLD_SAMPLES, hold);
        write_reg(REG_RELEASE_FACTOR, rel);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_CEILING_GAIN, ceil);
        // unknown index, must change nothing
        write_reg(REG_SPARE, $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Offer one frame, idling first at random; valid stays high after the handshake
    task automatic send_frame(input logic [23:0] left, input logic [23:0] right);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {right, left};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop offering and hold until every pending frame has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (shadow.expected_frames.size() != 0);
    endtask

    function automatic int unsigned pick_gain();
        case ($urandom_range(5))
            0: return 0;
            1: return 65536;
            2: return 131071;
            3: return $urandom_range(131071);
            4: return $urandom_range(40000, 100000);
            default: return $urandom() & 32'h7FFFFF;
        endcase
    endfunction

    function automatic logic [23:0] pick_sample(input int unsigned loud);
        int v;
        case ($urandom_range(11))
            0: return S_MAX;
            1: return S_MIN;
            2, 3: return 24'($urandom());
            default: begin
                v = int'($urandom_range(loud));
                if ($urandom_range(1) == 1) v = -v;
                return 24'(v);
            end
        endcase
    endfunction

    task automatic randomize_settings();
        int unsigned hold, rel, thr;
        case ($urandom_range(5))
            0: hold = 0;
            1: hold = 1;
            2: hold = 375;
            3: hold = 65535;
            4: hold = $urandom() & 32'h7FFFFF;
            default: hold = $urandom_range(2, 64);
        endcase
        case ($urandom_range(4))
            0: rel = 0;
            1: rel = 65535;
            2: rel = 65454;
            default: rel = $urandom() & 32'h7FFFFF;
        endcase
        case ($urandom_range(6))
            0: thr = 0;
            1: thr = 1;
            2: thr = 8388607;
            3: thr = 8304721;
            4: thr = $urandom_range(8388607);
            default: thr = $urandom_range(100000, 8388607);
        endcase
        apply_settings(pick_gain(), ($urandom_range(4) != 0), ($urandom_range(9) == 0),
                       hold, rel, thr, pick_gain());
    endtask

    initial begin
        int unsigned loud;
        loud = 8388607;
        send_idle_pct = 13;
        recv_idle_pct = 66;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: silence, full scale of both signs, sign flips
        send_frame(24'd0, 24'd0);
        send_frame(S_MAX, S_MAX);
        send_frame(S_MIN, S_MIN);
        send_frame(S_MAX, S_MIN);
        send_frame(24'hFFFFFF, 24'd1);
        send_frame(24'd1, 24'hFFFFFF);
        wait_for_results();

        // Muted
        apply_settings(65536, 1, 1, 375, 65454, 8304721, 65536);
        send_frame(S_MAX, S_MIN);
        send_frame(24'd123, 24'hFFFFFB);
        wait_for_results();

        // Bypass at half gain: rounding of exact halves
        apply_settings(32768, 0, 0, 375, 65454, 8304721, 65536);
        send_frame(24'd1, 24'hFFFFFF);
        send_frame(24'd3, 24'hFFFFFD);
        wait_for_results();

        // Bypass with gain above unity saturates
        apply_settings(131071, 0, 0, 375, 65454, 8304721, 65536);
        send_frame(S_MAX, S_MIN);
        wait_for_results();

        // Zero hold, zero threshold, no release, ceiling above unity
        apply_settings(65536, 1, 0, 0, 0, 0, 131071);
        send_frame(24'd1000, 24'hFFF830);
        send_frame(24'd0, 24'd0);
        send_frame(S_MAX, S_MAX);
        wait_for_results();

        // Short hold, slowest release: hold expiry and decay
        apply_settings(65536, 1, 0, 2, 65535, 4000000, 131071);
        send_frame(S_MAX, S_MIN);
        repeat (4) send_frame(24'd100, 24'd100);
        wait_for_results();

        // Random phases with varied settings and loudness
        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = (ph < 4) ? 13 : (ph < 8) ? 66 : 0;
            recv_idle_pct = (ph < 4) ? 66 : (ph < 8) ? 13 : 0;
            randomize_settings();
            if (ph == 8) stall_cycles = HOLD_OFF;
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                if (ph == 9 && n == FRAMES_PER_PHASE / 2) wait_for_results();
                if ($urandom_range(19) == 0) loud = $urandom_range(8388607) >> $urandom_range(20);
                send_frame(pick_sample(loud), pick_sample(loud));
            end
            wait_for_results();
        end

        repeat (40) @(posedge aclk);
        if (shadow.mismatch_count == 0 && shadow.expected_frames.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
